// File: design/mptm_pkg.sv
// Shared codes and types for the multi-prefix trie matcher.
// No dependencies; mptm_regs and the matcher top import this package.
`timescale 1ns / 1ps

package mptm_pkg;

    // Item kinds
    localparam logic [1:0] KIND_KEY_BYTE = 2'd0;
    localparam logic [1:0] KIND_KEY_END  = 2'd1;
    localparam logic [1:0] KIND_TEXT     = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_EDGE    = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_WRONG_MODE = 2'd3;

    // Configuration port geometry: one 32-bit register at byte address 0
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr[PADDR_W-1]
    localparam logic REG_SEARCH_MODE = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NODE,
        S_CHECK
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [15:0] tag;
        logic        last;
    } item_t;

endpackage

// File: design/mptm_if.sv
// Valid/ready channel interfaces for the trie matcher: input items and results.
// Depends on nothing; field widths are fixed by the item format.
`timescale 1ns / 1ps

interface mptm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] tag;
    logic        last;

    modport source (output valid, output kind, output byte_value, output tag, output last,
                    input ready);
    modport sink   (input valid, input kind, input byte_value, input tag, input last,
                    output ready);
endinterface

interface mptm_result_if;
    logic        valid;
    logic        ready;
    logic        matched;
    logic [15:0] match_tag;
    logic [1:0]  status;
    logic        text_end;

    modport source (output valid, output matched, output match_tag, output status,
                    output text_end, input ready);
    modport sink   (input valid, input matched, input match_tag, input status,
                    input text_end, output ready);
endinterface

// File: design/mptm_regs.sv
// APB-style register block of the trie matcher: holds the search_mode bit.
// Depends on mptm_pkg.
`timescale 1ns / 1ps

module mptm_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mptm_pkg::PADDR_W-1:0] paddr,
    input  logic [mptm_pkg::PDATA_W-1:0] pwdata,
    output logic [mptm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic                        search_mode
);
    import mptm_pkg::*;

    logic search_mode_reg;
    logic search_mode_next;
    logic hit_mode;

    assign hit_mode = (paddr[PADDR_W-1] == REG_SEARCH_MODE);

    always_comb
    begin
        search_mode_next = search_mode_reg;
        if (psel && penable && pwrite && hit_mode)
        begin
            search_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_mode_reg <= 1'b0;
        end
        else
        begin
            search_mode_reg <= search_mode_next;
        end
    end

    assign pready      = 1'b1;
    assign prdata      = hit_mode ? {{(PDATA_W-1){1'b0}}, search_mode_reg} : '0;
    assign search_mode = search_mode_reg;

endmodule

// File: design/multi_prefix_trie_matcher.sv
// Top level of the multi-prefix trie matcher: walk control, child and node memories.
// Depends on mptm_pkg, mptm_if (item and result channels) and mptm_regs.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   req     | in  | valid/ready        | kind, byte_value, tag, last
//   rsp     | out | valid/ready        | matched, match_tag, status, text_end
//   apb     | in  | psel/penable/pready| paddr, pwdata, pwrite -> prdata
//
// A walking beat passes through the child read at acceptance, the node read in S_NODE
// and the edge check in S_CHECK, which loads its result; any other beat loads its
// result in S_NODE. One beat is in flight at a time and the next is taken once the
// result is registered; a result still waiting there holds the following beat in its
// last state. No clearing pass after reset: an edge counts only if its child lies
// below the node count and records this very parent and symbol.
`timescale 1ns / 1ps

module multi_prefix_trie_matcher #(
    parameter int MAX_NODES = 256,
    parameter int ALPHABET  = 256,
    parameter int TAG_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mptm_item_if.sink                     req,
    mptm_result_if.source                 rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mptm_pkg::PADDR_W-1:0]  paddr,
    input  logic [mptm_pkg::PDATA_W-1:0]  pwdata,
    output logic [mptm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import mptm_pkg::*;

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = NODE_W + 1;
    localparam int SYM_W       = $clog2(ALPHABET);
    localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
    localparam int CADDR_W     = $clog2(CHILD_DEPTH);

    // Each node records how it was reached, so a stale child entry can be told apart
    typedef struct packed {
        logic [NODE_W-1:0]   parent;
        logic [SYM_W-1:0]    sym;
        logic                tag_valid;
        logic [TAG_BITS-1:0] tag;
    } node_ent_t;

    // Configuration
    logic search_mode;

    mptm_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .search_mode (search_mode)
    );

    // Memories
    logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
    node_ent_t         node_mem  [MAX_NODES];

    logic               child_ren;
    logic [CADDR_W-1:0] child_raddr;
    logic               child_we;
    logic [CADDR_W-1:0] child_waddr;
    logic [NODE_W-1:0]  child_wdata;
    logic [NODE_W-1:0]  child_rdata_reg;

    logic              node_ren;
    logic [NODE_W-1:0] node_raddr;
    logic              node_we;
    logic [NODE_W-1:0] node_waddr;
    node_ent_t         node_wdata;
    node_ent_t         node_rdata_reg;

    // Control state
    state_t             state_reg,          state_next;
    item_t              item_reg,           item_next;
    logic [NODE_W-1:0]  load_cursor_reg,    load_cursor_next;
    logic [NODE_W-1:0]  load_parent_reg,    load_parent_next;
    logic [SYM_W-1:0]   load_sym_reg,       load_sym_next;
    logic               load_failed_reg,    load_failed_next;
    logic [NODE_W-1:0]  search_cursor_reg,  search_cursor_next;
    logic               search_stopped_reg, search_stopped_next;
    logic [CNT_W-1:0]   node_count_reg,     node_count_next;

    // Output register
    logic        out_valid_reg,   out_valid_next;
    logic        out_matched_reg, out_matched_next;
    logic [15:0] out_tag_reg,     out_tag_next;
    logic [1:0]  out_status_reg,  out_status_next;
    logic        out_end_reg,     out_end_next;

    // Address of the child entry for the incoming beat
    logic               in_sym_ok;
    logic [SYM_W-1:0]   in_sym;
    logic [NODE_W-1:0]  in_cursor;

    // Held beat
    logic               sym_ok;
    logic [SYM_W-1:0]   sym_r;
    logic [NODE_W-1:0]  cursor_r;
    logic [CADDR_W-1:0] caddr_r;
    logic               edge_hit;
    logic               out_free;
    logic               accept;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign in_sym_ok = ({1'b0, req.byte_value} < 9'(ALPHABET));
    assign in_sym    = in_sym_ok ? SYM_W'(req.byte_value) : '0;
    assign in_cursor = (req.kind == KIND_TEXT) ? search_cursor_reg : load_cursor_reg;

    assign child_ren   = accept;
    assign child_raddr = CADDR_W'(CADDR_W'(in_cursor) * CADDR_W'(ALPHABET)
                                  + CADDR_W'(in_sym));

    assign sym_ok   = ({1'b0, item_reg.byte_value} < 9'(ALPHABET));
    assign sym_r    = sym_ok ? SYM_W'(item_reg.byte_value) : '0;
    assign cursor_r = (item_reg.kind == KIND_TEXT) ? search_cursor_reg : load_cursor_reg;
    assign caddr_r  = CADDR_W'(CADDR_W'(cursor_r) * CADDR_W'(ALPHABET) + CADDR_W'(sym_r));

    // A child entry is genuine only when its node was allocated from this edge
    assign edge_hit = (child_rdata_reg != '0)
                   && ({1'b0, child_rdata_reg} < node_count_reg)
                   && (node_rdata_reg.parent == cursor_r)
                   && (node_rdata_reg.sym == sym_r);

    always_comb
    begin
        state_next          = state_reg;
        item_next           = item_reg;
        load_cursor_next    = load_cursor_reg;
        load_parent_next    = load_parent_reg;
        load_sym_next       = load_sym_reg;
        load_failed_next    = load_failed_reg;
        search_cursor_next  = search_cursor_reg;
        search_stopped_next = search_stopped_reg;
        node_count_next     = node_count_reg;

        out_valid_next   = out_valid_reg && !rsp.ready;
        out_matched_next = out_matched_reg;
        out_tag_next     = out_tag_reg;
        out_status_next  = out_status_reg;
        out_end_next     = out_end_reg;

        node_ren    = 1'b0;
        node_raddr  = child_rdata_reg;
        node_we     = 1'b0;
        node_waddr  = load_cursor_reg;
        node_wdata  = '0;
        child_we    = 1'b0;
        child_waddr = caddr_r;
        child_wdata = node_count_reg[NODE_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = '{kind: req.kind, byte_value: req.byte_value,
                                   tag: req.tag, last: req.last};
                    state_next = S_NODE;
                end
            end

            S_NODE:
            begin
                // Walk beats go on to the node read; the rest finish here
                if (item_reg.kind == KIND_TEXT && search_mode && !search_stopped_reg
                    && sym_ok)
                begin
                    node_ren   = 1'b1;
                    state_next = S_CHECK;
                end
                else if (item_reg.kind == KIND_KEY_BYTE && !search_mode
                         && !load_failed_reg && sym_ok)
                begin
                    node_ren   = 1'b1;
                    state_next = S_CHECK;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_matched_next = 1'b0;
                    out_tag_next     = '0;
                    out_end_next     = 1'b0;
                    state_next       = S_IDLE;
                    case (item_reg.kind)
                        KIND_TEXT:
                        begin
                            out_end_next = item_reg.last;
                            if (!search_mode)
                            begin
                                out_status_next = ST_WRONG_MODE;
                            end
                            else
                            begin
                                // Stopped walk or symbol outside the alphabet
                                out_status_next     = ST_NO_EDGE;
                                search_stopped_next = 1'b1;
                                if (item_reg.last)
                                begin
                                    search_cursor_next  = '0;
                                    search_stopped_next = 1'b0;
                                end
                            end
                        end
                        KIND_KEY_BYTE:
                        begin
                            if (search_mode)
                            begin
                                out_status_next = ST_WRONG_MODE;
                            end
                            else if (load_failed_reg)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                out_status_next  = ST_NO_EDGE;
                                load_failed_next = 1'b1;
                            end
                        end
                        KIND_KEY_END:
                        begin
                            if (search_mode)
                            begin
                                out_status_next = ST_WRONG_MODE;
                            end
                            else
                            begin
                                if (load_failed_reg)
                                begin
                                    out_status_next = ST_FULL;
                                end
                                else
                                begin
                                    // Store the tag, keep how the node was reached
                                    out_status_next = ST_OK;
                                    node_we         = 1'b1;
                                    node_waddr      = load_cursor_reg;
                                    node_wdata      = '{parent: load_parent_reg,
                                                        sym: load_sym_reg,
                                                        tag_valid: 1'b1,
                                                        tag: TAG_BITS'(item_reg.tag)};
                                end
                                load_failed_next = 1'b0;
                                load_cursor_next = '0;
                                load_parent_next = '0;
                                load_sym_next    = '0;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_WRONG_MODE;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_matched_next = 1'b0;
                    out_tag_next     = '0;
                    out_status_next  = ST_OK;
                    out_end_next     = 1'b0;
                    state_next       = S_IDLE;
                    if (item_reg.kind == KIND_TEXT)
                    begin
                        out_end_next = item_reg.last;
                        if (edge_hit)
                        begin
                            search_cursor_next = child_rdata_reg;
                            if (node_rdata_reg.tag_valid)
                            begin
                                out_matched_next = 1'b1;
                                out_tag_next     = 16'(node_rdata_reg.tag);
                            end
                        end
                        else
                        begin
                            search_stopped_next = 1'b1;
                            out_status_next     = ST_NO_EDGE;
                        end
                        if (item_reg.last)
                        begin
                            search_cursor_next  = '0;
                            search_stopped_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if (edge_hit)
                        begin
                            load_cursor_next = child_rdata_reg;
                            load_parent_next = load_cursor_reg;
                            load_sym_next    = sym_r;
                        end
                        else if (node_count_reg >= CNT_W'(MAX_NODES))
                        begin
                            load_failed_next = 1'b1;
                            out_status_next  = ST_FULL;
                        end
                        else
                        begin
                            // Allocate: link the edge and record the new node's origin
                            child_we         = 1'b1;
                            child_waddr      = caddr_r;
                            child_wdata      = node_count_reg[NODE_W-1:0];
                            node_we          = 1'b1;
                            node_waddr       = node_count_reg[NODE_W-1:0];
                            node_wdata       = '{parent: load_cursor_reg, sym: sym_r,
                                                 tag_valid: 1'b0, tag: '0};
                            load_cursor_next = node_count_reg[NODE_W-1:0];
                            load_parent_next = load_cursor_reg;
                            load_sym_next    = sym_r;
                            node_count_next  = CNT_W'(node_count_reg + CNT_W'(1));
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_waddr] <= child_wdata;
        end
        if (child_ren)
        begin
            child_rdata_reg <= child_mem[child_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_ren)
        begin
            node_rdata_reg <= node_mem[node_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            load_cursor_reg    <= '0;
            load_parent_reg    <= '0;
            load_sym_reg       <= '0;
            load_failed_reg    <= 1'b0;
            search_cursor_reg  <= '0;
            search_stopped_reg <= 1'b0;
            node_count_reg     <= CNT_W'(1);
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            load_cursor_reg    <= load_cursor_next;
            load_parent_reg    <= load_parent_next;
            load_sym_reg       <= load_sym_next;
            load_failed_reg    <= load_failed_next;
            search_cursor_reg  <= search_cursor_next;
            search_stopped_reg <= search_stopped_next;
            node_count_reg     <= node_count_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        out_matched_reg <= out_matched_next;
        out_tag_reg     <= out_tag_next;
        out_status_reg  <= out_status_next;
        out_end_reg     <= out_end_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.matched   = out_matched_reg;
    assign rsp.match_tag = out_tag_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.text_end  = out_end_reg;

endmodule

// File: tb/sv/tb_multi_prefix_trie_matcher.sv
// Self-checking testbench for multi_prefix_trie_matcher: loads, searches, fills the trie.
// Depends on mptm_pkg, mptm_if and the matcher RTL; carries its own model of the trie.
`timescale 1ns / 1ps

module tb_multi_prefix_trie_matcher;

    import mptm_pkg::*;

    localparam int MAX_NODES = 256;
    localparam int ALPHABET  = 256;
    localparam int TAG_BITS  = 16;

    // Kind 3 has no meaning; the block must answer it with a wrong-mode status
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // Register 0 (search_mode) lies at byte address 0
    localparam logic [PADDR_W-1:0] ADDR_SEARCH_MODE = {REG_SEARCH_MODE, 2'b00};

    // Bounds for the drain loops and the final tail wait
    localparam int DRAIN_CYCLES = 20000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic        matched;
        logic [15:0] match_tag;
        logic [1:0]  status;
        logic        text_end;
    } beat_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    mptm_item_if   req_if ();
    mptm_result_if rsp_if ();

    multi_prefix_trie_matcher #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET),
        .TAG_BITS  (TAG_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow trie: the testbench's own copy of every table and cursor.
    // Child id 0 means "no edge", since the root is never a child.
    // ------------------------------------------------------------------
    logic [7:0]  shadow_child [0:MAX_NODES*ALPHABET-1];
    logic [15:0] shadow_tag   [0:MAX_NODES-1];
    logic        shadow_tag_ok[0:MAX_NODES-1];
    int          node_total;
    logic [7:0]  key_node;
    logic        key_failed;
    logic [7:0]  walk_node;
    logic        walk_stopped;
    logic        search_mode_q;

    // Results still owed by the block, oldest first
    beat_result_t pending_results[$];

    // Keys loaded so far, kept so that texts can follow real paths
    logic [63:0] key_bytes_q[$];
    int          key_len_q[$];

    int unsigned fail_cnt;

    // Idling switches, set per phase; off gives back-to-back stretches
    bit src_idle_on;
    bit snk_idle_on;

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Slowest correct run, every gap at its longest, stays under 2 ms; allow ten times that
    initial
    begin
        #20000000;
        $display("multi_prefix_trie_matcher test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction: advance the shadow trie by one accepted beat and return
    // the result that the block owes for it.
    // ------------------------------------------------------------------
    function automatic beat_result_t trie_step(input item_t it);
        beat_result_t r;
        logic [7:0]   nxt;
        r = '0;
        case (it.kind)
            KIND_TEXT:
            begin
                r.text_end = it.last;
                if (!search_mode_q)
                begin
                    r.status = ST_WRONG_MODE;
                end
                else
                begin
                    if (walk_stopped)
                    begin
                        r.status = ST_NO_EDGE;
                    end
                    else
                    begin
                        nxt = shadow_child[{walk_node, it.byte_value}];
                        if (nxt == 8'd0)
                        begin
                            // first missing edge: hold the walk until the text ends
                            walk_stopped = 1'b1;
                            r.status     = ST_NO_EDGE;
                        end
                        else
                        begin
                            walk_node = nxt;
                            if (shadow_tag_ok[nxt])
                            begin
                                r.matched   = 1'b1;
                                r.match_tag = shadow_tag[nxt];
                            end
                        end
                    end
                    if (it.last)
                    begin
                        walk_node    = 8'd0;
                        walk_stopped = 1'b0;
                    end
                end
            end
            KIND_KEY_BYTE:
            begin
                if (search_mode_q)
                begin
                    r.status = ST_WRONG_MODE;
                end
                else if (key_failed)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    nxt = shadow_child[{key_node, it.byte_value}];
                    if (nxt != 8'd0)
                    begin
                        key_node = nxt;
                    end
                    else if (node_total >= MAX_NODES)
                    begin
                        // table full: drop the rest of this key
                        key_failed = 1'b1;
                        r.status   = ST_FULL;
                    end
                    else
                    begin
                        nxt = 8'(node_total);
                        node_total++;
                        shadow_tag_ok[nxt] = 1'b0;
                        shadow_tag[nxt]    = '0;
                        shadow_child[{key_node, it.byte_value}] = nxt;
                        key_node = nxt;
                    end
                end
            end
            KIND_KEY_END:
            begin
                if (search_mode_q)
                begin
                    r.status = ST_WRONG_MODE;
                end
                else
                begin
                    if (key_failed)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        // a later key end at the same node overwrites the tag
                        shadow_tag[key_node]    = it.tag;
                        shadow_tag_ok[key_node] = 1'b1;
                    end
                    key_failed = 1'b0;
                    key_node   = 8'd0;
                end
            end
            default:
            begin
                r.status = ST_WRONG_MODE;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Narrow alphabet for most bytes so that keys share prefixes, plus the extremes and some random bytes
    function automatic logic [7:0] pick_key_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hff;
        else if (r < 12)
            return 8'(8'h61 + $urandom_range(0, 3));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_tag();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        else if (r == 1)
            return 16'hffff;
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // ------------------------------------------------------------------
    // Item channel driver: present one beat, hold it until it is taken,
    // record what the block owes, then idle for a random gap. With no gap
    // valid stays high for the next beat.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] kind, input logic [7:0] byte_value,
                             input logic [15:0] tag, input logic last);
        item_t it;
        int    gap;
        it.kind       = kind;
        it.byte_value = byte_value;
        it.tag        = tag;
        it.last       = last;
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.byte_value <= byte_value;
        req_if.tag        <= tag;
        req_if.last       <= last;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_results.push_back(trie_step(it));
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Off-mode or reserved beat with random content; the block must reject it
    task automatic send_noise(input bit in_search);
        logic [1:0] kind;
        if ($urandom_range(0, 3) == 0)
            kind = KIND_RESERVED;
        else if (in_search)
            kind = $urandom_range(0, 1) ? KIND_KEY_BYTE : KIND_KEY_END;
        else
            kind = KIND_TEXT;
        send_item(kind, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
    endtask

    // Drop valid and hold until every owed result has arrived or max_cycles run out
    task automatic wait_results_done(input int max_cycles);
        int waited;
        waited = 0;
        req_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_results.size() != 0 && waited < max_cycles);
    endtask

    // Write search_mode with the block idle, then read it back
    task automatic write_search_mode(input logic mode);
        logic [PDATA_W-1:0] word;
        word = {{(PDATA_W-1){1'b0}}, mode};
        wait_results_done(DRAIN_CYCLES);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SEARCH_MODE;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        search_mode_q = mode;
        // back-to-back read: new setup phase straight after the write
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== word)
        begin
            $error("prdata: expected %h, got %h", word, prdata);
            fail_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence builders
    // ------------------------------------------------------------------

    // Load n keys; a few are empty, a few long, some left without a key end,
    // and off-mode beats are scattered in between.
    task automatic load_keys(input int n, input bit wide_bytes);
        int          len;
        int          r;
        logic [63:0] kb;
        logic [7:0]  b;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 19);
            if (wide_bytes)
                len = 8;
            else if (r == 0)
                len = 0;
            else if (r < 3)
                len = $urandom_range(5, 8);
            else
                len = $urandom_range(1, 4);
            kb = '0;
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_noise(1'b0);
                b = wide_bytes ? 8'($urandom_range(0, 255)) : pick_key_byte();
                kb[8*i +: 8] = b;
                send_item(KIND_KEY_BYTE, b, 16'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)));
            end
            // broken sequence: now and then run straight into the next key
            if ($urandom_range(0, 19) != 0)
                send_item(KIND_KEY_END, 8'($urandom_range(0, 255)), pick_tag(),
                          1'($urandom_range(0, 1)));
            if (len > 0)
            begin
                key_bytes_q.push_back(kb);
                key_len_q.push_back(len);
            end
        end
    endtask

    // Search n texts: most follow a loaded key (and may run past it), the rest
    // are random. Last marks the final byte, except in a few broken texts.
    task automatic search_texts(input int n);
        logic [7:0] txt[0:15];
        int         tl;
        int         k;
        int         cut;
        int         ext;
        for (int t = 0; t < n; t++)
        begin
            tl = 0;
            if (key_len_q.size() > 0 && $urandom_range(0, 9) < 7)
            begin
                k   = $urandom_range(0, key_len_q.size() - 1);
                cut = $urandom_range(1, key_len_q[k]);
                for (int i = 0; i < cut; i++)
                begin
                    txt[tl] = key_bytes_q[k][8*i +: 8];
                    tl++;
                end
                ext = $urandom_range(0, 3);
                if (ext == 1)
                begin
                    k   = $urandom_range(0, key_len_q.size() - 1);
                    cut = (key_len_q[k] < 3) ? key_len_q[k] : 3;
                    for (int i = 0; i < cut; i++)
                    begin
                        txt[tl] = key_bytes_q[k][8*i +: 8];
                        tl++;
                    end
                end
                else if (ext == 2)
                begin
                    txt[tl] = 8'($urandom_range(0, 255));
                    tl++;
                end
            end
            else
            begin
                cut = $urandom_range(1, 5);
                for (int i = 0; i < cut; i++)
                begin
                    txt[tl] = pick_key_byte();
                    tl++;
                end
            end
            for (int i = 0; i < tl; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_noise(1'b1);
                send_item(KIND_TEXT, txt[i], 16'($urandom_range(0, 65535)),
                          (i == tl - 1) && ($urandom_range(0, 19) != 0));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, every kind in both modes, empty key, overwrite, stopped walk,
    // cursor kept across a mode switch.
    task automatic test_directed();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        write_search_mode(1'b0);
        // text and reserved beats in load mode
        send_item(KIND_TEXT, 8'h00, 16'h0000, 1'b1);
        send_item(KIND_TEXT, 8'hff, 16'hffff, 1'b0);
        send_item(KIND_RESERVED, 8'hff, 16'hffff, 1'b1);
        // empty key: tag lands on the root and must never be reported
        send_item(KIND_KEY_END, 8'h00, 16'hffff, 1'b0);
        send_item(KIND_KEY_BYTE, 8'h00, 16'h0000, 1'b0);
        send_item(KIND_KEY_END, 8'hff, 16'h0000, 1'b1);
        send_item(KIND_KEY_BYTE, 8'h00, 16'hffff, 1'b1);
        send_item(KIND_KEY_BYTE, 8'hff, 16'h0000, 1'b0);
        send_item(KIND_KEY_END, 8'h00, 16'h1234, 1'b0);
        // same key again: overwrite the earlier tag
        send_item(KIND_KEY_BYTE, 8'h00, 16'h0000, 1'b0);
        send_item(KIND_KEY_END, 8'h00, 16'habcd, 1'b0);
        write_search_mode(1'b1);
        send_item(KIND_TEXT, 8'h00, 16'h0000, 1'b0);
        send_item(KIND_TEXT, 8'hff, 16'h0000, 1'b1);
        // missing edge, then a byte on the stopped walk, then back at the root
        send_item(KIND_TEXT, 8'h7f, 16'h0000, 1'b0);
        send_item(KIND_TEXT, 8'h00, 16'h0000, 1'b1);
        send_item(KIND_TEXT, 8'hff, 16'h0000, 1'b1);
        send_item(KIND_TEXT, 8'h00, 16'hffff, 1'b1);
        // key and reserved beats in search mode
        send_item(KIND_KEY_BYTE, 8'h00, 16'h0000, 1'b0);
        send_item(KIND_KEY_END, 8'h00, 16'h5555, 1'b1);
        send_item(KIND_RESERVED, 8'h00, 16'h0000, 1'b0);
        // leave the walk mid-text across two mode switches
        send_item(KIND_TEXT, 8'h00, 16'h0000, 1'b0);
        write_search_mode(1'b0);
        send_item(KIND_KEY_BYTE, 8'hff, 16'h0000, 1'b0);
        write_search_mode(1'b1);
        send_item(KIND_TEXT, 8'hff, 16'h0000, 1'b1);
        write_search_mode(1'b0);
        send_item(KIND_KEY_END, 8'h00, 16'h00ff, 1'b0);
    endtask

    // Alternate load and search phases on a growing trie, with one
    // mid-phase hold-off until every result is back.
    task automatic test_load_search_rounds();
        for (int rnd = 0; rnd < 5; rnd++)
        begin
            src_idle_on = (rnd != 0) && ($urandom_range(0, 3) != 0);
            snk_idle_on = (rnd != 0) && ($urandom_range(0, 3) != 0);
            write_search_mode(1'b0);
            load_keys(25, 1'b0);
            write_search_mode(1'b1);
            search_texts(15);
            wait_results_done(DRAIN_CYCLES);
            search_texts(15);
        end
    endtask

    // Fill the node table with wide random keys, keep loading past full,
    // then search the full trie.
    task automatic test_table_full();
        int guard;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        write_search_mode(1'b0);
        guard = 0;
        while (node_total < MAX_NODES && guard < 200)
        begin
            load_keys(1, 1'b1);
            guard++;
        end
        // past full: some keys fail at once, some walk known paths first
        load_keys(4, 1'b1);
        load_keys(6, 1'b0);
        write_search_mode(1'b1);
        search_texts(25);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls on ready, with stretches held high
    // ------------------------------------------------------------------
    initial
    begin : ready_driver
        int burst;
        int gap;
        forever
        begin
            rsp_if.ready <= 1'b1;
            burst = $urandom_range(1, 20);
            repeat (burst) @(posedge clk);
            gap = snk_idle_on ? pick_gap() : 0;
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Compare every accepted result beat with the oldest owed result
    always @(posedge clk)
    begin : result_check
        beat_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no result owed: matched %0d tag %h status %0d",
                       rsp_if.matched, rsp_if.match_tag, rsp_if.status);
                fail_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.matched !== want.matched)
                begin
                    $error("matched: expected %0d, got %0d", want.matched, rsp_if.matched);
                    fail_cnt++;
                end
                if (rsp_if.match_tag !== want.match_tag)
                begin
                    $error("match_tag: expected %h, got %h", want.match_tag, rsp_if.match_tag);
                    fail_cnt++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    fail_cnt++;
                end
                if (rsp_if.text_end !== want.text_end)
                begin
                    $error("text_end: expected %0d, got %0d", want.text_end, rsp_if.text_end);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // hold every input at a known value from time zero
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_if.valid      <= 1'b0;
        req_if.kind       <= KIND_KEY_BYTE;
        req_if.byte_value <= '0;
        req_if.tag        <= '0;
        req_if.last       <= 1'b0;

        // shadow trie in its reset state
        for (int i = 0; i < MAX_NODES * ALPHABET; i++)
            shadow_child[i] = 8'd0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            shadow_tag[i]    = '0;
            shadow_tag_ok[i] = 1'b0;
        end
        node_total    = 1;
        key_node      = 8'd0;
        key_failed    = 1'b0;
        walk_node     = 8'd0;
        walk_stopped  = 1'b0;
        search_mode_q = 1'b0;
        fail_cnt      = 0;
        src_idle_on   = 1'b0;
        snk_idle_on   = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_load_search_rounds();
        test_table_full();

        // drain, then wait out TAIL_CYCLES more so that any stray beat shows
        wait_results_done(DRAIN_CYCLES);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("multi_prefix_trie_matcher test passed");
        else
            $display("multi_prefix_trie_matcher test failed");
        $finish;
    end

endmodule

// File: files.f
design/mptm_pkg.sv
design/mptm_if.sv
design/mptm_regs.sv
design/multi_prefix_trie_matcher.sv
tb/sv/tb_multi_prefix_trie_matcher.sv
